// ----- design/i2ra_pkg.sv -----
// Shared constants, types and character mapping for the radix ASCII converter.
package i2ra_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int IN_W        = 64;
  localparam int RADIX_W     = 6;
  localparam int DIGIT_W     = 6;
  localparam int CHAR_W      = 7;
  localparam int LEN_W       = 7;
  localparam int STEP_W      = $clog2(VALUE_WIDTH);
  localparam int ADDR_W      = $clog2(VALUE_WIDTH);
  localparam int COUNT_W     = $clog2(VALUE_WIDTH + 1);

  localparam logic [RADIX_W-1:0] RADIX_MIN     = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX     = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] RADIX_DEFAULT = RADIX_W'(10);
  localparam logic [CHAR_W-1:0]  CH_ZERO       = CHAR_W'(48);
  localparam logic [CHAR_W-1:0]  CH_LOWER_A    = CHAR_W'(97);
  localparam logic [DIGIT_W-1:0] DEC_DIGITS    = DIGIT_W'(10);

  typedef struct packed {
    logic               done;
    logic               quot_zero;
    logic [DIGIT_W-1:0] rem;
  } div_res_t;

  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_DIGITS) begin
      c = CH_ZERO + CHAR_W'(d);
    end else begin
      c = CH_LOWER_A + CHAR_W'(d - DEC_DIGITS);
    end
    return c;
  endfunction

endpackage

// ----- design/i2ra_div.sv -----
// Bit-serial restoring divider of the magnitude by the radix, one quotient bit per cycle.
module i2ra_div (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   go,
  input  logic [i2ra_pkg::VALUE_WIDTH-1:0]       dividend,
  input  logic [i2ra_pkg::RADIX_W-1:0]           divisor,
  output logic [i2ra_pkg::VALUE_WIDTH-1:0]       quotient,
  output i2ra_pkg::div_res_t                     res
);
  import i2ra_pkg::*;

  logic [VALUE_WIDTH-1:0] q;
  logic [DIGIT_W-1:0]     rem;
  logic [STEP_W-1:0]      cnt;
  logic                   running;
  logic                   done;
  logic                   nz;

  logic [DIGIT_W:0]       sh;
  logic                   ge;
  logic [DIGIT_W:0]       diff;
  logic [DIGIT_W-1:0]     rem_next;

  always_comb begin
    sh       = {rem, q[VALUE_WIDTH-1]};
    ge       = (sh >= {1'b0, divisor});
    diff     = sh - {1'b0, divisor};
    rem_next = ge ? diff[DIGIT_W-1:0] : sh[DIGIT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else if (go) begin
      q       <= dividend;
      rem     <= '0;
      cnt     <= STEP_W'(VALUE_WIDTH - 1);
      nz      <= 1'b0;
      running <= 1'b1;
      done    <= 1'b0;
    end else if (running) begin
      q   <= {q[VALUE_WIDTH-2:0], ge};
      rem <= rem_next;
      nz  <= nz | ge;
      cnt <= cnt - STEP_W'(1);
      if (cnt == '0) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  assign quotient      = q;
  assign res.done      = done;
  assign res.quot_zero = ~nz;
  assign res.rem       = rem;

endmodule

// ----- design/i2ra_ram.sv -----
// Digit store: one write port, one registered read port.
module i2ra_ram (
  input  logic                          clk,
  input  logic                          we,
  input  logic [i2ra_pkg::ADDR_W-1:0]   waddr,
  input  logic [i2ra_pkg::DIGIT_W-1:0]  wdata,
  input  logic [i2ra_pkg::ADDR_W-1:0]   raddr,
  output logic [i2ra_pkg::DIGIT_W-1:0]  rdata
);
  import i2ra_pkg::*;

  logic [DIGIT_W-1:0] mem [VALUE_WIDTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- design/int64_to_radix_ascii_core.sv -----
// Top level: integer to ASCII digits in radix 2 to 36, most significant digit first.
//
// A number is taken when start is high and busy is low; busy then stays high
// until the last digit has been shown. Each digit is produced by a bit-serial
// restoring division, and the digits are stored and then read back in reverse.
// Each result beat is shown for exactly one cycle with strobe high; the
// receiver cannot stall it, so it must take every beat. minus_before marks
// the first beat of a negative number, and the beat with last high carries
// total_length, sign included.
module int64_to_radix_ascii_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [i2ra_pkg::IN_W-1:0]     value,
  input  logic                          treat_signed,
  input  logic [i2ra_pkg::RADIX_W-1:0]  radix,
  output logic                          strobe,
  output logic [i2ra_pkg::CHAR_W-1:0]   digit_char,
  output logic                          minus_before,
  output logic                          last,
  output logic [i2ra_pkg::LEN_W-1:0]    total_length
);
  import i2ra_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_RD,
    S_OUT
  } state_t;

  state_t                 state;
  logic                   neg;
  logic                   first;
  logic [RADIX_W-1:0]     rdx;
  logic [COUNT_W-1:0]     count;
  logic [ADDR_W-1:0]      ptr;

  logic [VALUE_WIDTH-1:0] v_in;
  logic                   neg_in;
  logic [VALUE_WIDTH-1:0] mag;
  logic [RADIX_W-1:0]     rdx_in;
  logic                   accept;

  logic                   go;
  logic [VALUE_WIDTH-1:0] dividend;
  logic [VALUE_WIDTH-1:0] quotient;
  div_res_t               div_res;
  logic                   we;
  logic [DIGIT_W-1:0]     rdata;

  always_comb begin
    v_in   = value[VALUE_WIDTH-1:0];
    neg_in = treat_signed & v_in[VALUE_WIDTH-1];
    mag    = neg_in ? (~v_in + VALUE_WIDTH'(1)) : v_in;
    rdx_in = ((radix < RADIX_MIN) || (radix > RADIX_MAX)) ? RADIX_DEFAULT : radix;
    accept = start && (state == S_IDLE);
    we     = (state == S_DIV) && div_res.done;
    go     = accept || (we && !div_res.quot_zero);
    dividend = accept ? mag : quotient;
  end

  i2ra_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (go),
    .dividend (dividend),
    .divisor  (rdx),
    .quotient (quotient),
    .res      (div_res)
  );

  i2ra_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (count[ADDR_W-1:0]),
    .wdata (div_res.rem),
    .raddr (ptr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      strobe       <= 1'b0;
      minus_before <= 1'b0;
      last         <= 1'b0;
      total_length <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            neg   <= neg_in;
            rdx   <= rdx_in;
            count <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_res.done) begin
            count <= count + COUNT_W'(1);
            if (div_res.quot_zero) begin
              ptr   <= count[ADDR_W-1:0];
              first <= 1'b1;
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          strobe       <= 1'b1;
          minus_before <= first & neg;
          last         <= (ptr == '0);
          total_length <= (ptr == '0) ? (LEN_W'(count) + LEN_W'(neg)) : '0;
          state        <= S_OUT;
        end
        S_OUT: begin
          strobe       <= 1'b0;
          minus_before <= 1'b0;
          last         <= 1'b0;
          total_length <= '0;
          first        <= 1'b0;
          if (last) begin
            state <= S_IDLE;
          end else begin
            ptr   <= ptr - ADDR_W'(1);
            state <= S_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy       = (state != S_IDLE);
  assign digit_char = digit_to_char(rdata);

  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy)
    else $error("result beat outside a conversion");

  a_flags_need_strobe: assert property (@(posedge clk) disable iff (rst)
    !strobe |-> (!minus_before && !last))
    else $error("flags raised without a result beat");

  a_last_length: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |-> (total_length != '0))
    else $error("final beat without a length");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted number did not raise busy");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> (state == S_DIV))
    else $error("divider finished outside the division phase");

endmodule

// ----- verif/tb.sv -----
// Testbench for int64_to_radix_ascii_core: directed and random numbers against a digit predictor.
module tb;
  import i2ra_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              minus_before;
    logic              last;
    logic [LEN_W-1:0]  total_length;
  } digit_beat_t;

  localparam logic [IN_W-1:0] VALUE_MASK =
    (VALUE_WIDTH >= 64) ? {IN_W{1'b1}} : ((IN_W'(1) << VALUE_WIDTH) - IN_W'(1));
  localparam logic [IN_W-1:0] MOST_NEGATIVE = IN_W'(1) << (VALUE_WIDTH - 1);

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [IN_W-1:0]     value = '0;
  logic                treat_signed = 1'b0;
  logic [RADIX_W-1:0]  radix = RADIX_DEFAULT;
  logic                busy;
  logic                strobe;
  logic [CHAR_W-1:0]   digit_char;
  logic                minus_before;
  logic                last;
  logic [LEN_W-1:0]    total_length;

  digit_beat_t pending_digits[$];
  int          mismatches = 0;

  int64_to_radix_ascii_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .value        (value),
    .treat_signed (treat_signed),
    .radix        (radix),
    .strobe       (strobe),
    .digit_char   (digit_char),
    .minus_before (minus_before),
    .last         (last),
    .total_length (total_length)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("int64_to_radix_ascii_core verification failed");
    $finish;
  end

  function automatic void predict_digits(input logic [IN_W-1:0] num, input logic as_signed,
                                         input logic [RADIX_W-1:0] base_in);
    logic [IN_W-1:0]    mag;
    logic [IN_W-1:0]    base;
    logic               neg;
    logic [DIGIT_W-1:0] digs[64];
    logic [DIGIT_W-1:0] d;
    int                 n;
    digit_beat_t        beat;
    mag = num & VALUE_MASK;
    if (base_in < RADIX_MIN || base_in > RADIX_MAX) begin
      base = IN_W'(RADIX_DEFAULT);
    end else begin
      base = IN_W'(base_in);
    end
    neg = as_signed && mag[VALUE_WIDTH-1];
    if (neg) begin
      mag = (~mag + IN_W'(1)) & VALUE_MASK;
    end
    n = 0;
    do begin
      digs[n] = DIGIT_W'(mag % base);
      mag = mag / base;
      n++;
    end while (mag != 0 && n < 64);
    for (int k = 0; k < n; k++) begin
      d = digs[n-1-k];
      beat.digit_char = (d < 10) ? CH_ZERO + CHAR_W'(d) : CH_LOWER_A + CHAR_W'(d - 10);
      beat.minus_before = (k == 0) && neg;
      beat.last = (k == n - 1);
      beat.total_length = beat.last ? LEN_W'(n + (neg ? 1 : 0)) : '0;
      pending_digits.push_back(beat);
    end
  endfunction

  function automatic logic [IN_W-1:0] pick_value();
    logic [IN_W-1:0] v;
    case ($urandom_range(0, 5))
      0, 1: v = {$urandom, $urandom};
      2: v = IN_W'($urandom_range(0, 1000));
      3: v = ~IN_W'($urandom_range(0, 1000)) + IN_W'(1);
      4: v = IN_W'(1) << $urandom_range(0, 63);
      default: v = (IN_W'(1) << $urandom_range(0, 63)) - IN_W'($urandom_range(0, 2));
    endcase
    return v;
  endfunction

  function automatic logic [RADIX_W-1:0] pick_radix();
    if ($urandom_range(0, 7) == 0) begin
      return RADIX_W'($urandom_range(0, 63));
    end
    return RADIX_W'($urandom_range(2, 36));
  endfunction

  always @(posedge clk) begin
    digit_beat_t want;
    if (!rst && strobe) begin
      if (pending_digits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected beat: char %0d minus %0b last %0b len %0d",
                   digit_char, minus_before, last, total_length);
        end
      end else begin
        want = pending_digits.pop_front();
        if (digit_char !== want.digit_char || minus_before !== want.minus_before ||
            last !== want.last || total_length !== want.total_length) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp char %0d minus %0b last %0b len %0d, got %0d %0b %0b %0d",
                     want.digit_char, want.minus_before, want.last, want.total_length,
                     digit_char, minus_before, last, total_length);
          end
        end
      end
    end
  end

  // leave start high on return so a following number can be offered without a gap
  task automatic send_number(input logic [IN_W-1:0] num, input logic as_signed,
                             input logic [RADIX_W-1:0] base);
    start <= 1'b1;
    value <= num;
    treat_signed <= as_signed;
    radix <= base;
    do begin
      @(posedge clk);
    end while (busy);
    predict_digits(num, as_signed, base);
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_digits();
    start <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk);
  endtask

  task automatic test_extremes();
    send_number('0, 1'b0, RADIX_W'(10));
    send_number('0, 1'b1, RADIX_W'(2));
    send_number(VALUE_MASK, 1'b0, RADIX_W'(2));
    send_number(MOST_NEGATIVE, 1'b1, RADIX_W'(2));
    send_number(MOST_NEGATIVE, 1'b1, RADIX_W'(10));
    send_number(MOST_NEGATIVE - IN_W'(1), 1'b1, RADIX_W'(10));
    send_number(VALUE_MASK, 1'b0, RADIX_W'(36));
    send_number(IN_W'(35), 1'b0, RADIX_W'(36));
    send_number(IN_W'(9), 1'b0, RADIX_W'(10));
    send_number(IN_W'(10), 1'b0, RADIX_W'(10));
  endtask

  task automatic test_radix_fallback();
    send_number(IN_W'(123456789), 1'b0, RADIX_W'(0));
    send_number(IN_W'(987), 1'b1, RADIX_W'(1));
    send_number(IN_W'(40), 1'b0, RADIX_W'(37));
    send_number(VALUE_MASK, 1'b1, RADIX_W'(63));
  endtask

  task automatic test_sign_handling();
    send_number(VALUE_MASK, 1'b1, RADIX_W'(16));
    send_number(VALUE_MASK, 1'b0, RADIX_W'(10));
    send_number(~IN_W'(35) + IN_W'(1), 1'b1, RADIX_W'(36));
    send_number(IN_W'(7), 1'b1, RADIX_W'(8));
  endtask

  task automatic test_random_traffic(input int items);
    bit gaps_on;
    for (int i = 0; i < items; i++) begin
      if (i % 10 == 0) begin
        gaps_on = ($urandom_range(0, 3) != 0);
      end
      send_number(pick_value(), 1'($urandom_range(0, 1)), pick_radix());
      if (gaps_on) begin
        case ($urandom_range(0, 2))
          0: hold_off($urandom_range(1, 19));
          1: begin
            start <= 1'b0;
            do begin
              @(posedge clk);
            end while (busy);
            repeat ($urandom_range(1, 19) - 1) @(posedge clk);
          end
          default: ;
        endcase
      end
    end
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 3; i++) begin
      send_number(pick_value(), 1'($urandom_range(0, 1)), pick_radix());
    end
    drain_digits();
    for (int i = 0; i < 3; i++) begin
      send_number(pick_value(), 1'($urandom_range(0, 1)), pick_radix());
    end
  endtask

  task automatic test_back_to_back(input int items);
    for (int i = 0; i < items; i++) begin
      send_number(pick_value(), 1'($urandom_range(0, 1)), pick_radix());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_extremes();
    test_radix_fallback();
    test_sign_handling();
    test_random_traffic(100);
    test_drain_pause();
    test_back_to_back(20);
    drain_digits();
    repeat (80) @(posedge clk);
    if (mismatches == 0 && pending_digits.size() == 0) begin
      $display("int64_to_radix_ascii_core verification clean");
    end else begin
      $display("int64_to_radix_ascii_core verification failed");
    end
    $finish;
  end

endmodule
